[hw/rtl/presence_light_monitor_fsm_macros.svh]
// assertion helpers used by the checker file
`ifndef PRESENCE_LIGHT_MONITOR_FSM_MACROS_SVH
`define PRESENCE_LIGHT_MONITOR_FSM_MACROS_SVH

// concurrent assertion, masked while reset is applied
`define PLM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// concurrent assertion that is checked in reset as well
`define PLM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/plm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plm_pkg
// types, codes and reset values of the presence and light monitor
// ----------------------------------------------------------------------------
package plm_pkg;

  localparam int TimeBits = 40;
  localparam int LimBits  = 25;
  localparam int LuxBits  = 16;

  // configuration register indexes
  localparam int CfgIdxBits = 2;
  localparam logic [CfgIdxBits-1:0] REG_PRES_LIMIT = 2'd0;
  localparam logic [CfgIdxBits-1:0] REG_LUX_LIMIT  = 2'd1;
  localparam logic [CfgIdxBits-1:0] REG_DARK_ENTER = 2'd2;
  localparam logic [CfgIdxBits-1:0] REG_DARK_EXIT  = 2'd3;

  localparam logic signed [LimBits-1:0] PRES_LIMIT_RST = 25'sd1000;
  localparam logic signed [LimBits-1:0] LUX_LIMIT_RST  = 25'sd5000;
  localparam logic [LuxBits-1:0]        DARK_ENTER_RST = 16'd10;
  localparam logic [LuxBits-1:0]        DARK_EXIT_RST  = 16'd30;

  // reported state codes
  localparam logic [2:0] PRES_CODE_DISABLED = 3'd0;
  localparam logic [2:0] PRES_CODE_NOPERSON = 3'd1;
  localparam logic [2:0] PRES_CODE_PENDING  = 3'd2;
  localparam logic [2:0] PRES_CODE_ACTIVE   = 3'd3;
  localparam logic [2:0] PRES_CODE_COOLDOWN = 3'd4;

  localparam logic [1:0] LIGHT_CODE_UNKNOWN = 2'd0;
  localparam logic [1:0] LIGHT_CODE_NORMAL  = 2'd1;
  localparam logic [1:0] LIGHT_CODE_DARK    = 2'd2;

  typedef enum logic [2:0] {
    CMD_START    = 3'd0,
    CMD_STOP     = 3'd1,
    CMD_PRES     = 3'd2,
    CMD_LUX      = 3'd3,
    CMD_CONF_EXP = 3'd4,
    CMD_COOL_EXP = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    T_KEEP   = 2'd0,
    T_START  = 2'd1,
    T_CANCEL = 2'd2
  } tcmd_e;

  typedef enum logic [4:0] {
    P_DISABLED = 5'b00001,
    P_NOPERSON = 5'b00010,
    P_PENDING  = 5'b00100,
    P_ACTIVE   = 5'b01000,
    P_COOLDOWN = 5'b10000
  } pres_e;

  typedef enum logic [2:0] {
    L_UNKNOWN = 3'b001,
    L_NORMAL  = 3'b010,
    L_DARK    = 3'b100
  } light_e;

  typedef struct packed {
    logic [2:0]          cmd;
    logic [TimeBits-1:0] now_time;
    logic                sample_valid;
    logic                sample_present;
    logic [TimeBits-1:0] sample_time;
    logic [LuxBits-1:0]  lux_level;
  } item_t;

  typedef struct packed {
    logic signed [LimBits-1:0] pres_limit;
    logic signed [LimBits-1:0] lux_limit;
    logic [LuxBits-1:0]        dark_enter;
    logic [LuxBits-1:0]        dark_exit;
  } cfg_t;

  typedef struct packed {
    tcmd_e      confirm_cmd;
    tcmd_e      cooldown_cmd;
    logic       camera;
    logic       recording;
    logic       torch;
    logic [2:0] presence;
    logic [1:0] light;
  } result_t;

  function automatic logic [2:0] pres_code(pres_e p);
    logic [2:0] c;
    case (p)
      P_NOPERSON: c = PRES_CODE_NOPERSON;
      P_PENDING:  c = PRES_CODE_PENDING;
      P_ACTIVE:   c = PRES_CODE_ACTIVE;
      P_COOLDOWN: c = PRES_CODE_COOLDOWN;
      default:    c = PRES_CODE_DISABLED;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] light_code(light_e l);
    logic [1:0] c;
    case (l)
      L_NORMAL: c = LIGHT_CODE_NORMAL;
      L_DARK:   c = LIGHT_CODE_DARK;
      default:  c = LIGHT_CODE_UNKNOWN;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/plm_fresh.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plm_fresh
// sample freshness check: valid, not in the future, age within the limit
// ----------------------------------------------------------------------------
module plm_fresh
  import plm_pkg::*;
(
  input  wire logic                      valid_i,
  input  wire logic [TimeBits-1:0]       at_i,
  input  wire logic [TimeBits-1:0]       now_i,
  input  wire logic signed [LimBits-1:0] limit_i,
  output logic                           fresh_o
);

  localparam int CmpW = (TimeBits > LimBits) ? TimeBits : LimBits;

  logic [TimeBits:0]   diff;
  logic [CmpW-1:0]     age_ext;
  logic [CmpW-1:0]     lim_ext;

  // extra top bit is the borrow: set when the sample lies in the future
  assign diff    = {1'b0, now_i} - {1'b0, at_i};
  assign age_ext = CmpW'(diff[TimeBits-1:0]);
  assign lim_ext = CmpW'(limit_i[LimBits-2:0]);

  assign fresh_o = valid_i && !limit_i[LimBits-1] && !diff[TimeBits] && (age_ext <= lim_ext);

endmodule
`default_nettype wire

[hw/rtl/plm_fsm.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plm_fsm
// presence and light state machines with the stored presence sample
// ----------------------------------------------------------------------------
module plm_fsm
  import plm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire item_t item_i,
  input  wire cfg_t  cfg_i,
  output result_t    res_o
);

  pres_e               pres_q, pres_d;
  light_e              light_q, light_d;
  logic                last_valid_q, last_valid_d;
  logic                last_present_q, last_present_d;
  logic [TimeBits-1:0] last_time_q, last_time_d;

  logic                      use_last;
  logic                      f_valid;
  logic [TimeBits-1:0]       f_at;
  logic signed [LimBits-1:0] f_limit;
  logic                      fresh;
  logic                      pres_fresh;
  logic                      cam;
  tcmd_e                     ct, dt;
  cmd_e                      cmd;

  assign cmd = cmd_e'(item_i.cmd);

  // expiry events judge the stored sample, sample events the new one
  assign use_last = (cmd == CMD_CONF_EXP) || (cmd == CMD_COOL_EXP);
  assign f_valid  = use_last ? last_valid_q : item_i.sample_valid;
  assign f_at     = use_last ? last_time_q  : item_i.sample_time;
  assign f_limit  = (cmd == CMD_LUX) ? cfg_i.lux_limit : cfg_i.pres_limit;

  plm_fresh u_fresh (
    .valid_i (f_valid),
    .at_i    (f_at),
    .now_i   (item_i.now_time),
    .limit_i (f_limit),
    .fresh_o (fresh)
  );

  assign pres_fresh = fresh && (use_last ? last_present_q : item_i.sample_present);

  always_comb begin
    pres_d         = pres_q;
    light_d        = light_q;
    last_valid_d   = last_valid_q;
    last_present_d = last_present_q;
    last_time_d    = last_time_q;
    ct             = T_KEEP;
    dt             = T_KEEP;
    case (cmd)
      CMD_START, CMD_STOP: begin
        pres_d         = (cmd == CMD_START) ? P_NOPERSON : P_DISABLED;
        light_d        = L_UNKNOWN;
        last_valid_d   = 1'b0;
        last_present_d = 1'b0;
        last_time_d    = '0;
        ct             = T_CANCEL;
        dt             = T_CANCEL;
      end
      CMD_PRES: begin
        last_valid_d   = item_i.sample_valid;
        last_present_d = item_i.sample_present;
        last_time_d    = item_i.sample_time;
        if (pres_q == P_NOPERSON && pres_fresh) begin
          pres_d = P_PENDING;
          ct     = T_START;
        end else if (pres_q == P_PENDING && !pres_fresh) begin
          pres_d = P_NOPERSON;
          ct     = T_CANCEL;
        end else if (pres_q == P_ACTIVE && !pres_fresh) begin
          pres_d = P_COOLDOWN;
          ct     = T_CANCEL;
          dt     = T_START;
        end else if (pres_q == P_COOLDOWN && pres_fresh) begin
          pres_d = P_ACTIVE;
          ct     = T_CANCEL;
          dt     = T_CANCEL;
        end
      end
      CMD_LUX: begin
        // hysteresis: enter dark at or below one level, leave at or above another
        if (!fresh) begin
          light_d = L_UNKNOWN;
        end else if (light_q == L_NORMAL) begin
          if (item_i.lux_level <= cfg_i.dark_enter) light_d = L_DARK;
        end else if (light_q == L_DARK) begin
          if (item_i.lux_level >= cfg_i.dark_exit) light_d = L_NORMAL;
        end else begin
          light_d = (item_i.lux_level <= cfg_i.dark_enter) ? L_DARK : L_NORMAL;
        end
      end
      CMD_CONF_EXP: begin
        ct = T_CANCEL;
        if (pres_q == P_PENDING) pres_d = pres_fresh ? P_ACTIVE : P_NOPERSON;
      end
      CMD_COOL_EXP: begin
        dt = T_CANCEL;
        if (pres_q == P_COOLDOWN) pres_d = pres_fresh ? P_ACTIVE : P_NOPERSON;
      end
      default: begin
      end
    endcase
  end

  assign cam = (pres_d == P_ACTIVE) || (pres_d == P_COOLDOWN);

  always_comb begin
    res_o.confirm_cmd  = ct;
    res_o.cooldown_cmd = dt;
    res_o.camera       = cam;
    res_o.recording    = cam;
    res_o.torch        = cam && (light_d == L_DARK);
    res_o.presence     = pres_code(pres_d);
    res_o.light        = light_code(light_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pres_q         <= P_DISABLED;
      light_q        <= L_UNKNOWN;
      last_valid_q   <= 1'b0;
      last_present_q <= 1'b0;
      last_time_q    <= '0;
    end else if (en_i) begin
      pres_q         <= pres_d;
      light_q        <= light_d;
      last_valid_q   <= last_valid_d;
      last_present_q <= last_present_d;
      last_time_q    <= last_time_d;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/presence_light_monitor_fsm.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// presence_light_monitor_fsm
// presence and light monitor: one event in, one timer/wants result out
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_stall_o with cmd, now_time, the sample flags,
//   sample_time and lux_level; a transfer happens when valid is high and stall
//   is low at a rising edge
//   output channel: out_valid_o / out_stall_i with the timer commands, the
//   camera, recording and torch wants and both reported states
//   configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i at
//   the edge; write only while no event is in flight
//   result path: the event waits in the input register, then the state update
//   writes the result register, from which the result transfers
//   throughput: one event per cycle while the receiver does not stall; the
//   freshness subtract-and-compare and the state update sit in the single
//   stage between the two registers
//   receiver stall: the result register holds; one more event waits in the
//   input register, after which in_stall_o rises
//   reset: both machines go to disabled and unknown, the stored sample
//   clears, the configuration takes its default values, no result is valid
// ----------------------------------------------------------------------------
module presence_light_monitor_fsm
  import plm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration
  input  wire logic                  cfg_we_i,
  input  wire logic [CfgIdxBits-1:0] cfg_index_i,
  input  wire logic [LimBits-1:0]    cfg_wdata_i,
  // event input
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [2:0]            cmd_i,
  input  wire logic [TimeBits-1:0]   now_time_i,
  input  wire logic                  sample_valid_i,
  input  wire logic                  sample_present_i,
  input  wire logic [TimeBits-1:0]   sample_time_i,
  input  wire logic [LuxBits-1:0]    lux_level_i,
  // result output
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [1:0]                 confirm_timer_cmd_o,
  output logic [1:0]                 cooldown_timer_cmd_o,
  output logic                       camera_wanted_o,
  output logic                       recording_wanted_o,
  output logic                       torch_wanted_o,
  output logic [2:0]                 presence_now_o,
  output logic [1:0]                 light_now_o
);

  cfg_t    cfg_q;
  item_t   s1_item_q;
  logic    s1_valid_q, s1_valid_d;
  result_t res_q;
  result_t res_d;
  logic    out_valid_q, out_valid_d;
  logic    adv;
  logic    in_xfer;
  logic    step;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pres_limit <= PRES_LIMIT_RST;
      cfg_q.lux_limit  <= LUX_LIMIT_RST;
      cfg_q.dark_enter <= DARK_ENTER_RST;
      cfg_q.dark_exit  <= DARK_EXIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PRES_LIMIT: cfg_q.pres_limit <= cfg_wdata_i;
        REG_LUX_LIMIT:  cfg_q.lux_limit  <= cfg_wdata_i;
        REG_DARK_ENTER: cfg_q.dark_enter <= cfg_wdata_i[LuxBits-1:0];
        REG_DARK_EXIT:  cfg_q.dark_exit  <= cfg_wdata_i[LuxBits-1:0];
        default: begin
        end
      endcase
    end
  end

  // result register free or draining this cycle
  assign adv        = !out_valid_q || !out_stall_i;
  // input register can take a transfer if it empties now or is empty
  assign in_stall_o = s1_valid_q && !adv;
  assign in_xfer    = in_valid_i && !in_stall_o;
  // the event in the input register updates state as it moves on
  assign step       = s1_valid_q && adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) s1_valid_d = 1'b1;
    else if (adv) s1_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else s1_valid_q <= s1_valid_d;
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q.cmd            <= cmd_i;
      s1_item_q.now_time       <= now_time_i;
      s1_item_q.sample_valid   <= sample_valid_i;
      s1_item_q.sample_present <= sample_present_i;
      s1_item_q.sample_time    <= sample_time_i;
      s1_item_q.lux_level      <= lux_level_i;
    end
  end

  plm_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (step),
    .item_i (s1_item_q),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  assign out_valid_d = adv ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (step) res_q <= res_d;
  end

  assign out_valid_o          = out_valid_q;
  assign confirm_timer_cmd_o  = res_q.confirm_cmd;
  assign cooldown_timer_cmd_o = res_q.cooldown_cmd;
  assign camera_wanted_o      = res_q.camera;
  assign recording_wanted_o   = res_q.recording;
  assign torch_wanted_o       = res_q.torch;
  assign presence_now_o       = res_q.presence;
  assign light_now_o          = res_q.light;

endmodule
`default_nettype wire

[hw/rtl/plm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plm_checker
// port-level checks of the presence and light monitor, bound to the top
// ----------------------------------------------------------------------------
`include "presence_light_monitor_fsm_macros.svh"

module plm_checker
  import plm_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_stall_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic [1:0]            confirm_timer_cmd_o,
  input wire logic [1:0]            cooldown_timer_cmd_o,
  input wire logic                  camera_wanted_o,
  input wire logic                  recording_wanted_o,
  input wire logic                  torch_wanted_o,
  input wire logic [2:0]            presence_now_o,
  input wire logic [1:0]            light_now_o
);

  // after an edge in reset neither channel shows activity
  `PLM_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o && !in_stall_o, "busy in reset")

  // input only backs up behind a stalled result
  `PLM_ASSERT(a_stall_cause, clk_i, rst_ni, in_stall_o |-> out_valid_o && out_stall_i, "stall without cause")

  // a stalled result holds
  `PLM_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(confirm_timer_cmd_o) && $stable(cooldown_timer_cmd_o) && $stable(presence_now_o) && $stable(light_now_o) && $stable(torch_wanted_o), "stalled result changed")

  // torch only with camera on and dark light, camera only when active or in cooldown
  `PLM_ASSERT(a_wants, clk_i, rst_ni, out_valid_o |-> (!torch_wanted_o || (camera_wanted_o && light_now_o == LIGHT_CODE_DARK)) && (camera_wanted_o == (presence_now_o == PRES_CODE_ACTIVE || presence_now_o == PRES_CODE_COOLDOWN)) && (recording_wanted_o == camera_wanted_o), "wants disagree with states")

endmodule

bind presence_light_monitor_fsm plm_checker u_plm_checker (.*);
`default_nettype wire

[tb/tb_presence_light_monitor_fsm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_presence_light_monitor_fsm
// self-checking bench for the presence and light monitor
// ----------------------------------------------------------------------------
// events are sent over the valid/stall input channel with random gaps. Every
// event that transfers is run through a behavioural model of both machines
// kept in the bench, and the outcome is queued. Each result that transfers
// is checked field by field against the oldest queued outcome while the
// receiver stalls at random. Registers are rewritten between phases, once
// the block has gone idle, covering the limit and threshold extremes.
// ----------------------------------------------------------------------------
module tb_presence_light_monitor_fsm;
  import plm_pkg::*;

  // command codes the block must ignore
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  localparam int QUIET_LIMIT = 4000;

  // ---------------------------------------------------------------------------
  // block ports
  // ---------------------------------------------------------------------------
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_index_i = '0;
  logic [LimBits-1:0]    cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [2:0]            cmd_i = '0;
  logic [TimeBits-1:0]   now_time_i = '0;
  logic                  sample_valid_i = 1'b0;
  logic                  sample_present_i = 1'b0;
  logic [TimeBits-1:0]   sample_time_i = '0;
  logic [LuxBits-1:0]    lux_level_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [1:0]            confirm_timer_cmd_o;
  logic [1:0]            cooldown_timer_cmd_o;
  logic                  camera_wanted_o;
  logic                  recording_wanted_o;
  logic                  torch_wanted_o;
  logic [2:0]            presence_now_o;
  logic [1:0]            light_now_o;

  presence_light_monitor_fsm DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .cmd_i                (cmd_i),
    .now_time_i           (now_time_i),
    .sample_valid_i       (sample_valid_i),
    .sample_present_i     (sample_present_i),
    .sample_time_i        (sample_time_i),
    .lux_level_i          (lux_level_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .confirm_timer_cmd_o  (confirm_timer_cmd_o),
    .cooldown_timer_cmd_o (cooldown_timer_cmd_o),
    .camera_wanted_o      (camera_wanted_o),
    .recording_wanted_o   (recording_wanted_o),
    .torch_wanted_o       (torch_wanted_o),
    .presence_now_o       (presence_now_o),
    .light_now_o          (light_now_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // bench state
  // ---------------------------------------------------------------------------
  // monitor model: registers, both machines and the stored presence sample
  logic signed [LimBits-1:0] lim_presence = PRES_LIMIT_RST;
  logic signed [LimBits-1:0] lim_lux      = LUX_LIMIT_RST;
  logic [LuxBits-1:0]        lvl_dark_enter = DARK_ENTER_RST;
  logic [LuxBits-1:0]        lvl_dark_exit  = DARK_EXIT_RST;
  logic [2:0]                presence_code = PRES_CODE_DISABLED;
  logic [1:0]                light_code_now = LIGHT_CODE_UNKNOWN;
  logic                      stored_valid = 1'b0;
  logic                      stored_present = 1'b0;
  logic [TimeBits-1:0]       stored_time = '0;

  result_t expected_outcomes[$];
  int      mismatch_count = 0;
  int      results_seen = 0;
  int      quiet_cycles = 0;
  bit      idle_enabled = 1'b1;
  logic [TimeBits-1:0] clock_ms = '0;

  // ---------------------------------------------------------------------------
  // random helpers
  // ---------------------------------------------------------------------------
  // mostly no pause, some short ones, a few long ones
  function automatic int pause_length();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_enabled || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [TimeBits-1:0] rand40();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TimeBits-1:0];
  endfunction

  // sample stamp placed around the freshness window of the given limit
  function automatic logic [TimeBits-1:0] sample_stamp(logic [TimeBits-1:0] now_ms,
                                                       logic signed [LimBits-1:0] lim);
    logic [TimeBits-1:0] span;
    int r;
    span = (lim < 0) ? 40'd1000 : {15'd0, lim};
    r = $urandom_range(0, 99);
    if (r < 55) return now_ms - (rand40() % (span + 40'd1));
    if (r < 65) return now_ms - span;
    if (r < 75) return now_ms - span - 40'd1;
    if (r < 85) return now_ms + TimeBits'($urandom_range(1, 50));
    if (r < 93) return now_ms - TimeBits'($urandom_range(0, 3));
    return rand40();
  endfunction

  // lux readings clustered on the hysteresis thresholds
  function automatic logic [LuxBits-1:0] lux_reading();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return lvl_dark_enter;
    if (r < 30) return lvl_dark_enter + 16'd1;
    if (r < 45) return lvl_dark_exit;
    if (r < 55) return lvl_dark_exit - 16'd1;
    if (r < 70) return LuxBits'($urandom_range(0, lvl_dark_enter));
    if (r < 80) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    return LuxBits'($urandom_range(0, 16'hFFFF));
  endfunction

  // ---------------------------------------------------------------------------
  // monitor model
  // ---------------------------------------------------------------------------
  function automatic logic sample_is_fresh(logic vld, logic [TimeBits-1:0] at_ms,
                                           logic [TimeBits-1:0] now_ms,
                                           logic signed [LimBits-1:0] lim);
    if (!vld || lim < 0 || at_ms > now_ms) return 1'b0;
    return (now_ms - at_ms) <= {15'd0, lim};
  endfunction

  // advances both machines by one event and returns the result it gives
  function automatic result_t predict_outcome(logic [2:0] code, logic [TimeBits-1:0] now_ms,
                                              logic vld, logic pres,
                                              logic [TimeBits-1:0] at_ms,
                                              logic [LuxBits-1:0] lux);
    result_t r;
    logic    fresh;
    logic    cam;
    r.confirm_cmd  = T_KEEP;
    r.cooldown_cmd = T_KEEP;
    case (code)
      CMD_START, CMD_STOP: begin
        presence_code  = (code == CMD_START) ? PRES_CODE_NOPERSON : PRES_CODE_DISABLED;
        light_code_now = LIGHT_CODE_UNKNOWN;
        stored_valid   = 1'b0;
        stored_present = 1'b0;
        stored_time    = '0;
        r.confirm_cmd  = T_CANCEL;
        r.cooldown_cmd = T_CANCEL;
      end
      CMD_PRES: begin
        stored_valid   = vld;
        stored_present = pres;
        stored_time    = at_ms;
        fresh = sample_is_fresh(vld, at_ms, now_ms, lim_presence) && pres;
        if (presence_code == PRES_CODE_NOPERSON && fresh) begin
          presence_code = PRES_CODE_PENDING;
          r.confirm_cmd = T_START;
        end else if (presence_code == PRES_CODE_PENDING && !fresh) begin
          presence_code = PRES_CODE_NOPERSON;
          r.confirm_cmd = T_CANCEL;
        end else if (presence_code == PRES_CODE_ACTIVE && !fresh) begin
          presence_code  = PRES_CODE_COOLDOWN;
          r.confirm_cmd  = T_CANCEL;
          r.cooldown_cmd = T_START;
        end else if (presence_code == PRES_CODE_COOLDOWN && fresh) begin
          presence_code  = PRES_CODE_ACTIVE;
          r.confirm_cmd  = T_CANCEL;
          r.cooldown_cmd = T_CANCEL;
        end
      end
      CMD_LUX: begin
        if (!sample_is_fresh(vld, at_ms, now_ms, lim_lux)) begin
          light_code_now = LIGHT_CODE_UNKNOWN;
        end else if (light_code_now == LIGHT_CODE_UNKNOWN) begin
          light_code_now = (lux <= lvl_dark_enter) ? LIGHT_CODE_DARK : LIGHT_CODE_NORMAL;
        end else if (light_code_now == LIGHT_CODE_NORMAL) begin
          if (lux <= lvl_dark_enter) light_code_now = LIGHT_CODE_DARK;
        end else begin
          if (lux >= lvl_dark_exit) light_code_now = LIGHT_CODE_NORMAL;
        end
      end
      CMD_CONF_EXP, CMD_COOL_EXP: begin
        if (code == CMD_CONF_EXP) r.confirm_cmd = T_CANCEL;
        else r.cooldown_cmd = T_CANCEL;
        // an expiry only moves the machine from the state that armed it
        if (presence_code ==
            ((code == CMD_CONF_EXP) ? PRES_CODE_PENDING : PRES_CODE_COOLDOWN)) begin
          fresh = sample_is_fresh(stored_valid, stored_time, now_ms, lim_presence) &&
                  stored_present;
          presence_code = fresh ? PRES_CODE_ACTIVE : PRES_CODE_NOPERSON;
        end
      end
      default: begin
      end
    endcase
    cam = (presence_code == PRES_CODE_ACTIVE) || (presence_code == PRES_CODE_COOLDOWN);
    r.camera    = cam;
    r.recording = cam;
    r.torch     = cam && (light_code_now == LIGHT_CODE_DARK);
    r.presence  = presence_code;
    r.light     = light_code_now;
    return r;
  endfunction

  // register writes and input transfers, both seen at the clock edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_PRES_LIMIT: lim_presence   = cfg_wdata_i;
          REG_LUX_LIMIT:  lim_lux        = cfg_wdata_i;
          REG_DARK_ENTER: lvl_dark_enter = cfg_wdata_i[LuxBits-1:0];
          REG_DARK_EXIT:  lvl_dark_exit  = cfg_wdata_i[LuxBits-1:0];
          default: begin
          end
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        expected_outcomes.push_back(predict_outcome(cmd_i, now_time_i, sample_valid_i,
                                                    sample_present_i, sample_time_i,
                                                    lux_level_i));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("%0t: %s", $realtime, msg);
  endtask

  task automatic score_field(string what, logic [3:0] got, logic [3:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s mismatch: got %0d, expected %0d",
                                results_seen, what, got, want));
    end
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_outcomes.size() == 0) begin
        report_mismatch("result transfer with no event outstanding");
      end else begin
        want = expected_outcomes.pop_front();
        score_field("confirm timer command", 4'(confirm_timer_cmd_o), 4'(want.confirm_cmd));
        score_field("cooldown timer command", 4'(cooldown_timer_cmd_o),
                    4'(want.cooldown_cmd));
        score_field("camera wanted", 4'(camera_wanted_o), 4'(want.camera));
        score_field("recording wanted", 4'(recording_wanted_o), 4'(want.recording));
        score_field("torch wanted", 4'(torch_wanted_o), 4'(want.torch));
        score_field("presence state", 4'(presence_now_o), 4'(want.presence));
        score_field("light state", 4'(light_now_o), 4'(want.light));
      end
      results_seen++;
    end
  end

  // watchdog: too long without any transfer on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("presence_light_monitor_fsm test failed");
      $finish;
    end
  end

  // receiver back-pressure: alternating stall and run stretches
  initial begin : result_stall_gen
    int hold;
    int run;
    @(posedge clk_i);
    forever begin
      hold = pause_length();
      run  = pause_length();
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ((run != 0) ? run : 1) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  // one event transfer; returns at the edge that takes it, valid left high
  task automatic send_event(logic [2:0] code, logic [TimeBits-1:0] now_ms, logic vld,
                            logic pres, logic [TimeBits-1:0] at_ms,
                            logic [LuxBits-1:0] lux);
    int gap;
    gap = pause_length();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    cmd_i            <= code;
    now_time_i       <= now_ms;
    sample_valid_i   <= vld;
    sample_present_i <= pres;
    sample_time_i    <= at_ms;
    lux_level_i      <= lux;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // let every outstanding result drain, then let the pipeline settle
  task automatic drain_results();
    in_valid_i <= 1'b0;
    // wait for the clock first so the last transfer is surely queued
    @(posedge clk_i);
    while (expected_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // writes all four registers on back-to-back edges; block must be idle
  task automatic apply_settings(logic [LimBits-1:0] pres_lim, logic [LimBits-1:0] lux_lim,
                                logic [LimBits-1:0] enter_word,
                                logic [LimBits-1:0] exit_word);
    logic [LimBits-1:0] words[4];
    words[REG_PRES_LIMIT] = pres_lim;
    words[REG_LUX_LIMIT]  = lux_lim;
    words[REG_DARK_ENTER] = enter_word;
    words[REG_DARK_EXIT]  = exit_word;
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= CfgIdxBits'(i);
      cfg_wdata_i <= words[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // one random event, mostly shaped as a plausible session
  task automatic random_event();
    logic [2:0]          code;
    logic                vld;
    logic                pres;
    logic [TimeBits-1:0] at_ms;
    logic [LuxBits-1:0]  lux;
    int                  r;
    clock_ms = clock_ms + (($urandom_range(0, 19) == 0) ? $urandom_range(0, 20000)
                                                         : $urandom_range(0, 300));
    // fields the command does not use still carry random values
    vld   = 1'($urandom_range(0, 1));
    pres  = 1'($urandom_range(0, 1));
    at_ms = rand40();
    lux   = LuxBits'($urandom_range(0, 16'hFFFF));
    r     = $urandom_range(0, 99);
    if (presence_code == PRES_CODE_DISABLED && r < 70) begin
      code = CMD_START;
    end else if (r < 3) begin
      code = CMD_START;
    end else if (r < 5) begin
      code = CMD_STOP;
    end else if (r < 45) begin
      code  = CMD_PRES;
      vld   = ($urandom_range(0, 9) != 0);
      pres  = ($urandom_range(0, 99) < 65);
      at_ms = sample_stamp(clock_ms, lim_presence);
    end else if (r < 68) begin
      code  = CMD_LUX;
      vld   = ($urandom_range(0, 9) != 0);
      at_ms = sample_stamp(clock_ms, lim_lux);
      lux   = lux_reading();
    end else if (r < 85) begin
      // the expiry a running timer would raise
      if (presence_code == PRES_CODE_PENDING) code = CMD_CONF_EXP;
      else if (presence_code == PRES_CODE_COOLDOWN) code = CMD_COOL_EXP;
      else code = ($urandom_range(0, 1) != 0) ? CMD_CONF_EXP : CMD_COOL_EXP;
    end else if (r < 94) begin
      code = ($urandom_range(0, 1) != 0) ? CMD_CONF_EXP : CMD_COOL_EXP;
    end else if (r < 97) begin
      code = ($urandom_range(0, 1) != 0) ? CMD_SPARE_A : CMD_SPARE_B;
    end else begin
      // pure noise, any command code and any stamps
      code = 3'($urandom_range(0, 7));
      send_event(code, rand40(), vld, pres, at_ms, lux);
      return;
    end
    send_event(code, clock_ms, vld, pres, at_ms, lux);
  endtask

  task automatic random_run(int count);
    clock_ms = rand40();
    for (int i = 0; i < count; i++) begin
      // occasional stretches with no pauses on either side
      if (i % 40 == 0) idle_enabled = ($urandom_range(0, 3) != 0);
      random_event();
    end
    idle_enabled = 1'b1;
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // walk both machines through their main transitions at the default settings
  task automatic test_directed();
    logic [TimeBits-1:0] t_max;
    t_max = '1;
    // stored while disabled, nothing else moves
    send_event(CMD_PRES, 40'd5000, 1'b1, 1'b1, 40'd4900, 16'd0);
    send_event(CMD_CONF_EXP, 40'd5000, 1'b0, 1'b0, 40'd0, 16'd0);
    send_event(CMD_START, 40'd5000, 1'b0, 1'b0, 40'd0, 16'd0);
    // cooldown expiry with no cooldown running
    send_event(CMD_COOL_EXP, 40'd5000, 1'b0, 1'b0, 40'd0, 16'd0);
    // age exactly at the limit still counts
    send_event(CMD_PRES, 40'd6000, 1'b1, 1'b1, 40'd5000, 16'd0);
    send_event(CMD_CONF_EXP, 40'd6000, 1'b0, 1'b0, 40'd0, 16'd0);
    send_event(CMD_LUX, 40'd6000, 1'b1, 1'b0, 40'd1000, 16'd0);
    // hysteresis: below the exit level stays dark, then back and forth
    send_event(CMD_LUX, 40'd6000, 1'b1, 1'b0, 40'd6000, 16'd29);
    send_event(CMD_LUX, 40'd6000, 1'b1, 1'b0, 40'd6000, 16'hFFFF);
    send_event(CMD_LUX, 40'd6000, 1'b1, 1'b0, 40'd6000, 16'd10);
    send_event(CMD_PRES, 40'd6100, 1'b1, 1'b0, 40'd6100, 16'd0);
    send_event(CMD_PRES, 40'd6200, 1'b1, 1'b1, 40'd6200, 16'd0);
    // one past the limit is stale
    send_event(CMD_PRES, 40'd7201, 1'b1, 1'b1, 40'd6200, 16'd0);
    send_event(CMD_COOL_EXP, 40'd7300, 1'b0, 1'b0, 40'd0, 16'd0);
    // sample stamped in the future
    send_event(CMD_PRES, 40'd7300, 1'b1, 1'b1, 40'd7301, 16'd0);
    send_event(CMD_PRES, 40'd7400, 1'b1, 1'b1, 40'd7400, 16'd0);
    send_event(CMD_PRES, 40'd7400, 1'b0, 1'b1, 40'd7400, 16'd0);
    send_event(CMD_PRES, 40'd7500, 1'b1, 1'b1, 40'd7500, 16'd0);
    // stored sample has gone stale by the time confirmation expires
    send_event(CMD_CONF_EXP, 40'd9000, 1'b0, 1'b0, 40'd0, 16'd0);
    send_event(CMD_LUX, 40'd9000, 1'b0, 1'b1, 40'd9000, 16'd0);
    send_event(CMD_SPARE_A, 40'd9000, 1'b1, 1'b1, 40'd9000, 16'hFFFF);
    send_event(CMD_SPARE_B, 40'd9000, 1'b1, 1'b1, 40'd9000, 16'hFFFF);
    // time extremes
    send_event(CMD_LUX, t_max, 1'b1, 1'b1, t_max, 16'hFFFF);
    send_event(CMD_PRES, t_max, 1'b1, 1'b1, 40'd0, 16'd0);
    send_event(CMD_PRES, 40'd0, 1'b1, 1'b1, t_max, 16'd0);
    send_event(CMD_STOP, t_max, 1'b1, 1'b1, t_max, 16'hFFFF);
    drain_results();
  endtask

  // limits and thresholds at their extremes
  task automatic test_config_extremes();
    apply_settings(25'd0, 25'd0, 25'd0, 25'd0);
    random_run(110);
    apply_settings(25'h0FFFFFF, 25'h0FFFFFF, 25'h000FFFF, 25'h000FFFF);
    random_run(110);
    // all ones: every sample is stale
    apply_settings(25'h1FFFFFF, 25'h1FFFFFF, DARK_ENTER_RST, DARK_EXIT_RST);
    random_run(110);
    apply_settings(25'h1000000, LUX_LIMIT_RST, 25'h000FFFF, 25'd0);
    random_run(110);
    apply_settings(PRES_LIMIT_RST, 25'h1000000, 25'd0, 25'h000FFFF);
    random_run(110);
    apply_settings(25'd0, 25'h0FFFFFF, DARK_ENTER_RST, DARK_EXIT_RST);
    random_run(110);
  endtask

  // random settings, level words carrying junk in the unused upper bits
  task automatic test_random_settings();
    logic [LimBits-1:0] lims[2];
    logic [LuxBits-1:0] lo;
    logic [LuxBits-1:0] hi;
    int                 r;
    for (int phase = 0; phase < 10; phase++) begin
      for (int k = 0; k < 2; k++) begin
        r = $urandom_range(0, 99);
        if (r < 10) lims[k] = 25'h1000000 | LimBits'($urandom_range(0, 25'h0FFFFFF));
        else if (r < 80) lims[k] = LimBits'($urandom_range(0, 2000));
        else lims[k] = LimBits'($urandom_range(0, 25'h0FFFFFF));
      end
      lo = LuxBits'($urandom_range(0, 16'hFFFF));
      hi = LuxBits'($urandom_range(0, 16'hFFFF));
      // usually a proper hysteresis band, sometimes inverted
      if ($urandom_range(0, 3) != 0 && lo > hi) begin
        lo = lo ^ hi;
        hi = lo ^ hi;
        lo = lo ^ hi;
      end
      apply_settings(lims[0], lims[1], {9'($urandom), lo}, {9'($urandom), hi});
      random_run(120);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_random_settings();
    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("presence_light_monitor_fsm test passed");
    end else begin
      $display("presence_light_monitor_fsm test failed");
    end
    $finish;
  end

endmodule
